FILE: hw/rtl/bqc_pkg.sv
// Shared types and constants for the cascaded Q31 biquad filter.
// No dependencies; imported by bqc_mac and biquad_cascade_q31_df1_unit.
package bqc_pkg;

  localparam int DATA_W          = 32;
  localparam int CFG_W           = 4;
  localparam int IDX_W           = 6;
  localparam int COEFS_PER_STAGE = 5;
  localparam int HIST_PER_STAGE  = 4;
  localparam int IN_TDATA_W      = 72;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

endpackage

FILE: hw/rtl/bqc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bqc_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 40,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bqc_mac.sv
// Q31 multiply-accumulate unit: registered 32x32 product, rounded high-word accumulate.
// Depends on bqc_pkg.
module bqc_mac (
  input  logic               clk,
  input  bqc_pkg::mac_ctl_t  ctl,
  input  bqc_pkg::data_t     coef,
  input  bqc_pkg::data_t     opnd,
  output bqc_pkg::data_t     acc
);
  import bqc_pkg::*;

  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [2*DATA_W-1:0] prod_nxt;
  data_t                      acc_r;
  data_t                      acc_nxt;
  logic [DATA_W-1:0]          base;
  logic [2*DATA_W-1:0]        sum;

  assign prod_nxt = coef * opnd;
  assign base     = ctl.acc_clr ? '0 : acc_r;
  assign sum      = {base, {DATA_W{1'b0}}} + prod_r
                    + {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
  assign acc_nxt  = sum[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: hw/rtl/biquad_cascade_q31_df1_unit.sv
// Cascaded Direct Form I biquad, Q31. Sequencer, coefficient and history RAMs.
// Depends on bqc_pkg, bqc_ram, bqc_mac.
//
//  port group | dir | payload
//  in_*       | in  | tuser: opcode; tdata: sample, coef_index, coef_value
//  out_*      | out | tdata: filtered
//  cfg_*      | in  | data: stages_in_use
//
// A sample's run time grows with the number of active stages, set by the single
// shared MAC and the one read port per RAM: each stage reads 5 coefficients and
// 4 history words over 8 steps.
// Reset is synchronous; RAM entries read as zero until written (valid bits).
// A finished word waits in the output register; the sequencer holds in DONE
// only while that register is still full.
module biquad_cascade_q31_df1_unit #(
  parameter int MAX_STAGES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bqc_pkg::IN_TDATA_W-1:0]    in_tdata,  // sample, coef_index, coef_value
  input  logic                              in_tuser,  // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bqc_pkg::DATA_W-1:0]        out_tdata, // filtered
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bqc_pkg::CFG_W-1:0]         cfg_data   // stages_in_use
);
  import bqc_pkg::*;

  localparam int CDEPTH = COEFS_PER_STAGE * MAX_STAGES;
  localparam int HDEPTH = HIST_PER_STAGE * MAX_STAGES;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int STW    = $clog2(MAX_STAGES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] STEP_X1_WR  = 3'd2;
  localparam logic [2:0] STEP_X2_WR  = 3'd3;
  localparam logic [2:0] STEP_Y2_WR  = 3'd5;
  localparam logic [2:0] STEP_LAST   = 3'd7;
  localparam logic [2:0] STEP_RD_END = 3'd4;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       step_r;
  logic [STW-1:0]   stage_r, n_r, n_nxt;
  logic [CFG_W-1:0] stages_in_use_r;
  data_t            x_r, x1_r, y1_r;
  logic             out_tvalid_r;
  data_t            out_tdata_r;

  logic             opcode;
  data_t            sample;
  logic [IDX_W-1:0] coef_index;
  data_t            coef_value;
  logic             in_acc, coef_wr;

  logic [CDEPTH-1:0] coef_vld_r;
  logic [HDEPTH-1:0] hist_vld_r;
  logic              coef_rv_r, hist_rv_r;
  logic [CAW-1:0]    coef_raddr, coef_waddr;
  logic [HAW-1:0]    hist_raddr, hist_waddr;
  logic [DATA_W-1:0] coef_rdata, hist_rdata;
  data_t             coef_q, hist_q;
  logic [2:0]        coff;
  logic [1:0]        hoff_rd, hoff_wr;
  logic              hist_we;
  data_t             hist_wdata;

  mac_ctl_t ctl;
  data_t    mac_opnd, acc, y;
  logic     last_stage;

  assign opcode     = in_tuser;
  assign sample     = in_tdata[31:0];
  assign coef_index = in_tdata[37:32];
  assign coef_value = in_tdata[69:38];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign coef_wr   = in_acc && (opcode == OP_COEF) && (32'(coef_index) < CDEPTH);

  assign n_nxt = (32'(stages_in_use_r) > MAX_STAGES) ? STW'(MAX_STAGES)
                                                      : STW'(stages_in_use_r);

  // coefficient RAM: written from the input, read by the sequencer
  assign coff       = (step_r > STEP_RD_END) ? STEP_RD_END : step_r;
  assign coef_raddr = CAW'(32'(stage_r) * COEFS_PER_STAGE + 32'(coff));
  assign coef_waddr = CAW'(coef_index);

  bqc_ram #(.WIDTH(DATA_W), .DEPTH(CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_wr),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // history RAM: per stage x1, x2, y1, y2
  assign hoff_rd = 2'(step_r - 3'd1);
  always_comb begin
    hist_we    = 1'b0;
    hoff_wr    = 2'd0;
    hist_wdata = x_r;
    if (state_r == ST_RUN) begin
      unique case (step_r)
        STEP_X1_WR: begin
          hist_we    = 1'b1;
          hoff_wr    = 2'd0;
          hist_wdata = x_r;
        end
        STEP_X2_WR: begin
          hist_we    = 1'b1;
          hoff_wr    = 2'd1;
          hist_wdata = x1_r;
        end
        STEP_Y2_WR: begin
          hist_we    = 1'b1;
          hoff_wr    = 2'd3;
          hist_wdata = y1_r;
        end
        STEP_LAST: begin
          hist_we    = 1'b1;
          hoff_wr    = 2'd2;
          hist_wdata = y;
        end
        default: begin
          hist_we = 1'b0;
        end
      endcase
    end
  end

  assign hist_raddr = HAW'(32'(stage_r) * HIST_PER_STAGE + 32'(hoff_rd));
  assign hist_waddr = HAW'(32'(stage_r) * HIST_PER_STAGE + 32'(hoff_wr));

  bqc_ram #(.WIDTH(DATA_W), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign coef_q = coef_rv_r ? coef_rdata : '0;
  assign hist_q = hist_rv_r ? hist_rdata : '0;

  // MAC schedule: products on steps 1..5, accumulates on steps 2..6
  assign ctl.mul_en  = (state_r == ST_RUN) && (step_r >= 3'd1) && (step_r <= 3'd5);
  assign ctl.acc_en  = (state_r == ST_RUN) && (step_r >= 3'd2) && (step_r <= 3'd6);
  assign ctl.acc_clr = (step_r == 3'd2);
  assign mac_opnd    = (step_r == 3'd1) ? x_r : hist_q;

  bqc_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef_q),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  assign y          = {acc[DATA_W-2:0], 1'b0};
  assign last_stage = (stage_r == STW'(n_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (opcode == OP_SAMPLE)) begin
          state_nxt = (n_nxt == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if ((step_r == STEP_LAST) && last_stage) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      step_r          <= '0;
      stage_r         <= '0;
      n_r             <= '0;
      stages_in_use_r <= CFG_W'(1);
      out_tvalid_r    <= 1'b0;
      coef_vld_r      <= '0;
      hist_vld_r      <= '0;
      coef_rv_r       <= 1'b0;
      hist_rv_r       <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      coef_rv_r <= coef_vld_r[coef_raddr];
      hist_rv_r <= hist_vld_r[hist_raddr];
      if (cfg_valid && cfg_ready) begin
        stages_in_use_r <= cfg_data;
      end
      if (coef_wr) begin
        coef_vld_r[coef_waddr] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_r[hist_waddr] <= 1'b1;
      end
      if (in_acc && (opcode == OP_SAMPLE)) begin
        n_r     <= n_nxt;
        stage_r <= '0;
        step_r  <= '0;
      end else if (state_r == ST_RUN) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          stage_r <= stage_r + 1'b1;
        end
      end
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (opcode == OP_SAMPLE)) begin
      x_r <= (n_nxt == '0) ? '0 : sample;
    end else if ((state_r == ST_RUN) && (step_r == STEP_LAST)) begin
      x_r <= y;
    end
    if ((state_r == ST_RUN) && (step_r == 3'd2)) begin
      x1_r <= hist_q;
    end
    if ((state_r == ST_RUN) && (step_r == 3'd4)) begin
      y1_r <= hist_q;
    end
    if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= x_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (stage_r < n_r))
    else $error("stage index past active stage count");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_en |-> $past(ctl.mul_en))
    else $error("accumulate without a preceding product");

  a_hist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_we && (step_r >= 3'd1) && (step_r <= STEP_RD_END)) |-> (hist_waddr != hist_raddr))
    else $error("history read and write hit the same entry");

  a_run_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && (step_r == STEP_LAST) && last_stage) |=> (state_r == ST_DONE))
    else $error("sequencer missed the end of the cascade");
`endif

endmodule
